FILE: design/lc8_pkg.sv
// ----------------------------------------------------------------------------
// lc8_pkg: shared types and constants for the log8 code converter
// Operation codes, code layout constants, offset function, result bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package lc8_pkg;

  localparam int CodeW  = 8;
  localparam int ValueW = 20;
  localparam int InW    = 32;
  localparam int ExpW   = 4;
  localparam int ManW   = 4;

  localparam logic [ManW-1:0]   MaskNibble = 4'h0f;
  localparam logic [ExpW-1:0]   MaxExp     = 4'd15;
  localparam logic [CodeW-1:0]  SatCode    = 8'hFF;
  localparam logic [14:0]       OffMask    = 15'h7FFF;
  // smallest value that no longer fits at exponent 15: 16 * (2^16 - 1)
  localparam logic [ValueW-1:0] SatLimit   = 20'd1048560;

  typedef enum logic {
    KIND_DECODE = 1'b0,
    KIND_ENCODE = 1'b1
  } kind_t;

  typedef struct packed {
    logic [CodeW-1:0]  code;
    logic [ValueW-1:0] value;
    logic              saturated;
  } result_t;

  // offset of exponent e: 16 * (2^e - 1)
  function automatic logic [ValueW-1:0] exp_offset(input logic [ExpW-1:0] e);
    logic [14:0] ones;
    ones = OffMask >> (MaxExp - e);
    return {1'b0, ones, 4'b0000};
  endfunction

endpackage

`default_nettype wire

FILE: design/lc8_convert.sv
// ----------------------------------------------------------------------------
// lc8_convert: combinational code/value conversion
// Decode: (m << e) + offset(e). Encode: priority compare against the fixed
// offsets, then m = (v - offset) >> e, saturating to 0xFF when too large.
// ----------------------------------------------------------------------------
`default_nettype none

module lc8_convert (
  input  wire lc8_pkg::kind_t                kind,
  input  wire logic [lc8_pkg::CodeW-1:0]     code_in,
  input  wire logic [lc8_pkg::InW-1:0]       value_in,
  output lc8_pkg::result_t                   res
);

  logic [lc8_pkg::ExpW-1:0]   dec_e;
  logic [lc8_pkg::ManW-1:0]   dec_m;
  logic [lc8_pkg::ValueW-1:0] dec_value;
  logic [lc8_pkg::ExpW-1:0]   enc_e;
  logic [lc8_pkg::ValueW-1:0] enc_diff;
  logic [lc8_pkg::ValueW-1:0] enc_shift;
  logic                       enc_sat;
  logic [lc8_pkg::ValueW-1:0] v20;

  assign dec_e     = code_in[7:4];
  assign dec_m     = code_in[3:0] & lc8_pkg::MaskNibble;
  assign dec_value = ({16'd0, dec_m} << dec_e) + lc8_pkg::exp_offset(dec_e);

  assign v20     = value_in[lc8_pkg::ValueW-1:0];
  assign enc_sat = (value_in[lc8_pkg::InW-1:lc8_pkg::ValueW] != '0) ||
                   (v20 >= lc8_pkg::SatLimit);

  // largest exponent whose offset does not exceed the value; below 16 gives e = 0
  always_comb begin
    enc_e = '0;
    for (int k = 1; k <= 15; k++) begin
      if (lc8_pkg::exp_offset(k[lc8_pkg::ExpW-1:0]) <= v20) begin
        enc_e = k[lc8_pkg::ExpW-1:0];
      end
    end
  end

  assign enc_diff  = v20 - lc8_pkg::exp_offset(enc_e);
  assign enc_shift = enc_diff >> enc_e;

  always_comb begin
    res = '0;
    if (kind == lc8_pkg::KIND_ENCODE) begin
      if (enc_sat) begin
        res.code      = lc8_pkg::SatCode;
        res.saturated = 1'b1;
      end else begin
        res.code = {enc_e, enc_shift[lc8_pkg::ManW-1:0]};
      end
    end else begin
      res.value = dec_value;
    end
  end

endmodule

`default_nettype wire

FILE: design/log8_code_converter.sv
// ----------------------------------------------------------------------------
// log8_code_converter: 8-bit logarithmic code <-> unsigned integer
// Two-register pipeline: input register, conversion logic, result register.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------
//  in      | in_valid / in_stall  | kind, code_in, value_in
//  out     | out_valid / out_stall| code_out, value_out, saturated
//
//  One transaction per cycle sustained while out_stall is low; an accepted
//  input passes the input register, then the result register (out_valid).
//  The conversion is a single pass through the offset compare and shifter.
//  rst is synchronous and empties both stages.
//  out_stall holds the result register; in_stall rises only when both
//  stages are full and the result is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module log8_code_converter (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          kind,
  input  wire logic [lc8_pkg::CodeW-1:0]     code_in,
  input  wire logic [lc8_pkg::InW-1:0]       value_in,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [lc8_pkg::CodeW-1:0]          code_out,
  output logic [lc8_pkg::ValueW-1:0]         value_out,
  output logic                               saturated
);

  logic                      s1_valid;
  lc8_pkg::kind_t            s1_kind;
  logic [lc8_pkg::CodeW-1:0] s1_code;
  logic [lc8_pkg::InW-1:0]   s1_value;
  logic                      s2_load;
  lc8_pkg::result_t          conv;

  assign s2_load  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s2_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_kind  <= lc8_pkg::kind_t'(kind);
      s1_code  <= code_in;
      s1_value <= value_in;
    end
  end

  lc8_convert u_convert (
    .kind     (s1_kind),
    .code_in  (s1_code),
    .value_in (s1_value),
    .res      (conv)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      code_out  <= conv.code;
      value_out <= conv.value;
      saturated <= conv.saturated;
    end
  end

  // input side backs up only behind a stalled, full result register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a stalled result");

  // an item in the input register moves on when the result register is empty
  a_advance: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_valid) |=> out_valid)
    else $error("item not advanced into empty result register");

  a_sat_code: assert property (@(posedge clk) disable iff (rst)
    (out_valid && saturated) |-> (code_out == lc8_pkg::SatCode && value_out == '0))
    else $error("saturated result without clamped code");

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    (out_valid && value_out != '0) |-> (code_out == '0 && !saturated))
    else $error("decode result carries encode fields");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: log8 code converter
// Sends decode and encode transactions with random gaps and output stalls.
// Each result is checked against an in-line conversion model, oldest first.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  localparam int QuietLimit = 500;

  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       in_valid  = 1'b0;
  logic                       in_stall;
  logic                       kind      = 1'b0;
  logic [lc8_pkg::CodeW-1:0]  code_in   = '0;
  logic [lc8_pkg::InW-1:0]    value_in  = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [lc8_pkg::CodeW-1:0]  code_out;
  logic [lc8_pkg::ValueW-1:0] value_out;
  logic                       saturated;

  lc8_pkg::result_t conv_expected_q[$];
  lc8_pkg::result_t head_conv;
  int      mismatch_count = 0;
  int      quiet_cycles   = 0;
  int      stall_left     = 0;
  bit      idle_on        = 1'b1;

  log8_code_converter dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .code_in   (code_in),
    .value_in  (value_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .code_out  (code_out),
    .value_out (value_out),
    .saturated (saturated)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // 16 * (2^e - 1)
  function automatic logic [31:0] exp_base(input int e);
    return ((32'd1 << e) - 32'd1) << 4;
  endfunction

  function automatic lc8_pkg::result_t predict_conversion(input lc8_pkg::kind_t op,
                                                          input logic [lc8_pkg::CodeW-1:0] c,
                                                          input logic [lc8_pkg::InW-1:0] v);
    lc8_pkg::result_t r;
    logic [3:0]  e;
    logic [31:0] m;
    logic [31:0] dec;
    r = '0;
    if (op == lc8_pkg::KIND_DECODE) begin
      e = c[7:4];
      dec = (32'(c[3:0]) << e) + exp_base(int'(e));
      r.value = dec[lc8_pkg::ValueW-1:0];
    end else if (v < 32'd16) begin
      r.code = v[lc8_pkg::CodeW-1:0];
    end else begin
      e = 4'd0;
      for (int x = 1; x <= 15; x++)
        if (exp_base(x) <= v) e = 4'(x);
      m = (v - exp_base(int'(e))) >> e;
      if (m > 32'd15) begin
        r.code = lc8_pkg::SatCode;
        r.saturated = 1'b1;
      end else begin
        r.code = {e, m[3:0]};
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < 100)
      $display("ERROR t=%0t %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // one transaction on the input channel; expectation is queued on acceptance
  task automatic send_conversion(input lc8_pkg::kind_t op,
                                 input logic [lc8_pkg::CodeW-1:0] c,
                                 input logic [lc8_pkg::InW-1:0] v);
    int gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    @(negedge clk);
    repeat (gap) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    kind     = op;
    code_in  = c;
    value_in = v;
    do @(posedge clk); while (in_stall);
    conv_expected_q.push_back(predict_conversion(op, c, v));
  endtask

  task automatic drop_valid();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic logic [31:0] pick_encode_value();
    int e;
    e = $urandom_range(1, 15);
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 15);
      1, 2, 3: return exp_base(e) + $urandom_range(0, (32'd16 << e) - 1);
      4:       return exp_base(e) - 1 + $urandom_range(0, 2);
      5:       return 32'd1048559 + $urandom_range(0, 2);
      6, 7:    return $urandom();
      8:       return $urandom_range(16, 1048559);
      default: return $urandom() >> $urandom_range(0, 31);
    endcase
  endfunction

  task automatic send_random_item();
    if ($urandom_range(0, 1))
      send_conversion(lc8_pkg::KIND_ENCODE, 8'($urandom()), pick_encode_value());
    else
      send_conversion(lc8_pkg::KIND_DECODE, 8'($urandom()), $urandom());
  endtask

  task automatic test_decode_corners();
    logic [lc8_pkg::CodeW-1:0] codes[6];
    codes = '{8'h00, 8'h0F, 8'h10, 8'h7A, 8'hF0, 8'hFF};
    foreach (codes[i])
      send_conversion(lc8_pkg::KIND_DECODE, codes[i], $urandom());
  endtask

  task automatic test_encode_corners();
    // pass-through, first exponent steps, top exponent edges, saturation
    logic [31:0] vals[14];
    vals = '{32'd0, 32'd15, 32'd16, 32'd17, 32'd47, 32'd48, 32'd524271, 32'd524272,
             32'd1048559, 32'd1048560, 32'd1048561, 32'h8000_0000, 32'hFFFF_FFFF,
             32'h0000_FFFF};
    foreach (vals[i])
      send_conversion(lc8_pkg::KIND_ENCODE, 8'($urandom()), vals[i]);
  endtask

  task automatic test_random_mix(input int count);
    repeat (count) send_random_item();
  endtask

  // no gaps on either side
  task automatic test_back_to_back(input int count);
    idle_on = 1'b0;
    repeat (count) send_random_item();
    idle_on = 1'b1;
  endtask

  // sender holds off until every pending result has come back
  task automatic test_drain_pause();
    repeat (30) send_random_item();
    drop_valid();
    while (conv_expected_q.size() != 0) @(posedge clk);
    repeat (30) send_random_item();
  endtask

  always @(negedge clk) begin
    if (idle_on && stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else begin
      out_stall = 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (conv_expected_q.size() == 0) begin
        report_mismatch("result with nothing pending", 32'({code_out, saturated}), 32'd0);
      end else begin
        head_conv = conv_expected_q.pop_front();
        if (code_out !== head_conv.code)
          report_mismatch("code_out", 32'(code_out), 32'(head_conv.code));
        if (value_out !== head_conv.value)
          report_mismatch("value_out", 32'(value_out), 32'(head_conv.value));
        if (saturated !== head_conv.saturated)
          report_mismatch("saturated", 32'(saturated), 32'(head_conv.saturated));
      end
      stall_left = $urandom_range(0, 3);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("timeout: no transaction for %0d cycles", QuietLimit);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    stall_left = $urandom_range(0, 3);
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_decode_corners();
    test_encode_corners();
    test_random_mix(600);
    test_drain_pause();
    test_back_to_back(200);
    test_random_mix(600);
    drop_valid();
    while (conv_expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
